// ===== design/pfb_pkg.sv =====
// Package for the page framebuffer raster engine: operation codes, FSM states, command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pfb_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR  = 3'd0,
		KIND_PIXEL  = 3'd1,
		KIND_LINE   = 3'd2,
		KIND_CIRCLE = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CIR_TEST,
		ST_CIR_STEP,
		ST_READ,
		ST_READ_WAIT,
		ST_DONE
	} state_t;

	// point-source selector for the datapath
	typedef enum logic [1:0] {
		SRC_PIXEL,
		SRC_LINE,
		SRC_CIRCLE
	} src_t;

	typedef struct packed {
		logic load;       // capture the input item
		logic clr_start;  // reset clear sweep counter
		logic clr_write;  // write zero at sweep address
		logic rd_issue;   // issue memory read at current point or read address
		logic wr_issue;   // write modified byte
		logic pt_advance; // advance to next point of the figure
		logic cir_next;   // advance circle a/b after 8 points
		logic rd_capture; // capture read byte as result
		src_t src;
	} pfb_cmd_t;

	typedef struct packed {
		logic clr_last;  // sweep at last address
		logic pt_last;   // last point of current figure group
		logic cir_cont;  // circle loop condition holds
		logic line_end;  // all line points done
	} pfb_sts_t;

endpackage
`default_nettype wire

// ===== design/pfb_ctrl.sv =====
// Controller state machine for the page framebuffer raster engine.
// Depends on pfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic [2:0]        in_kind,
	input  wire logic              out_free,
	input  wire pfb_pkg::pfb_sts_t sts,
	output pfb_pkg::pfb_cmd_t      cmd,
	output logic                   busy,
	output logic                   done
);

	pfb_pkg::state_t state_q, state_nx;
	pfb_pkg::src_t src_q, src_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfb_pkg::ST_INIT;
			src_q   <= pfb_pkg::SRC_PIXEL;
		end else begin
			state_q <= state_nx;
			src_q   <= src_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		src_nx   = src_q;
		unique case (state_q)
			pfb_pkg::ST_INIT:      if (sts.clr_last) state_nx = pfb_pkg::ST_IDLE;
			pfb_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_kind)
						pfb_pkg::KIND_CLEAR:  state_nx = pfb_pkg::ST_CLEAR;
						pfb_pkg::KIND_PIXEL: begin
							state_nx = pfb_pkg::ST_PIX_RD;
							src_nx   = pfb_pkg::SRC_PIXEL;
						end
						pfb_pkg::KIND_LINE: begin
							state_nx = pfb_pkg::ST_PIX_RD;
							src_nx   = pfb_pkg::SRC_LINE;
						end
						pfb_pkg::KIND_CIRCLE: begin
							state_nx = pfb_pkg::ST_CIR_TEST;
							src_nx   = pfb_pkg::SRC_CIRCLE;
						end
						pfb_pkg::KIND_READ:   state_nx = pfb_pkg::ST_READ;
						default:              state_nx = pfb_pkg::ST_DONE;
					endcase
				end
			end
			pfb_pkg::ST_CLEAR:     if (sts.clr_last) state_nx = pfb_pkg::ST_DONE;
			pfb_pkg::ST_PIX_RD:    state_nx = pfb_pkg::ST_PIX_WR;
			pfb_pkg::ST_PIX_WR: begin
				if (src_q == pfb_pkg::SRC_PIXEL)
					state_nx = pfb_pkg::ST_DONE;
				else if (src_q == pfb_pkg::SRC_LINE)
					state_nx = sts.line_end ? pfb_pkg::ST_DONE : pfb_pkg::ST_PIX_RD;
				else
					state_nx = sts.pt_last ? pfb_pkg::ST_CIR_STEP : pfb_pkg::ST_PIX_RD;
			end
			pfb_pkg::ST_CIR_TEST:  state_nx = sts.cir_cont ? pfb_pkg::ST_PIX_RD
				: pfb_pkg::ST_DONE;
			pfb_pkg::ST_CIR_STEP:  state_nx = pfb_pkg::ST_CIR_TEST;
			pfb_pkg::ST_READ:      state_nx = pfb_pkg::ST_READ_WAIT;
			pfb_pkg::ST_READ_WAIT: state_nx = pfb_pkg::ST_DONE;
			pfb_pkg::ST_DONE:      if (out_free) state_nx = pfb_pkg::ST_IDLE;
			default:               state_nx = pfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.src        = src_q;
		cmd.load       = (state_q == pfb_pkg::ST_IDLE) && in_fire;
		cmd.clr_start  = cmd.load;
		cmd.clr_write  = (state_q == pfb_pkg::ST_CLEAR) || (state_q == pfb_pkg::ST_INIT);
		cmd.rd_issue   = (state_q == pfb_pkg::ST_PIX_RD) || (state_q == pfb_pkg::ST_READ);
		cmd.wr_issue   = (state_q == pfb_pkg::ST_PIX_WR);
		cmd.pt_advance = (state_q == pfb_pkg::ST_PIX_WR);
		cmd.cir_next   = (state_q == pfb_pkg::ST_CIR_STEP);
		cmd.rd_capture = (state_q == pfb_pkg::ST_READ_WAIT);
		busy           = (state_q != pfb_pkg::ST_IDLE);
		done           = (state_q == pfb_pkg::ST_DONE) && out_free;
	end

endmodule
`default_nettype wire

// ===== design/pfb_datapath.sv =====
// Datapath for the page framebuffer raster engine: frame store, line and circle steppers.
// Depends on pfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfb_datapath #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfb_pkg::pfb_cmd_t cmd,
	input  wire logic [2:0]        kind,
	input  wire logic [7:0]        x_a,
	input  wire logic [7:0]        y_a,
	input  wire logic [7:0]        x_b,
	input  wire logic [7:0]        y_b,
	input  wire logic [7:0]        radius,
	input  wire logic              pixel_on,
	input  wire logic [1:0]        read_page,
	output pfb_pkg::pfb_sts_t      sts,
	output logic [7:0]             read_data,
	output logic [2:0]             done_kind
);

	localparam int DEPTH = COLUMNS * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int ROWS  = PAGES * 8;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdat_q;

	// captured item
	logic [2:0]  kind_q;
	logic        on_q;
	logic [7:0]  rx_q;
	logic [1:0]  rpage_q;
	logic signed [9:0] cx_q, cy_q;     // centre / line current point
	logic [8:0]  dx_q, dy_q, dist_q;   // line magnitudes
	logic signed [1:0] sx_q, sy_q;
	logic [9:0]  ex_q, ey_q;
	logic [8:0]  cnt_q;                // line points drawn
	logic [8:0]  ca_q, cb_q;           // circle a, b
	logic [16:0] rr_q;
	logic [2:0]  oct_q;                // circle point within group of eight
	logic [AW:0] clr_q;
	logic [7:0]  res_q;
	logic        cir_done_q;

	// current point
	logic signed [10:0] px, py;
	logic signed [10:0] sa, sb;
	assign sa = $signed({2'b0, ca_q});
	assign sb = $signed({2'b0, cb_q});
	always_comb begin
		px = {cx_q[9], cx_q};
		py = {cy_q[9], cy_q};
		if (cmd.src == pfb_pkg::SRC_CIRCLE) begin
			case (oct_q)
				3'd0: begin px = cx_q + sa; py = cy_q - sb; end
				3'd1: begin px = cx_q - sa; py = cy_q - sb; end
				3'd2: begin px = cx_q - sa; py = cy_q + sb; end
				3'd3: begin px = cx_q + sa; py = cy_q + sb; end
				3'd4: begin px = cx_q + sb; py = cy_q + sa; end
				3'd5: begin px = cx_q + sb; py = cy_q - sa; end
				3'd6: begin px = cx_q - sb; py = cy_q - sa; end
				default: begin px = cx_q - sb; py = cy_q + sa; end
			endcase
		end
	end

	logic onscreen;
	logic [AW-1:0] paddr, raddr, addr;
	logic [2:0] pbit;
	logic [7:0] wbyte;
	logic wr_on;
	assign onscreen = (px >= 0) && (px < COLUMNS) && (py >= 0) && (py < ROWS);
	assign paddr = AW'(px[8:0]) * AW'(PAGES) + AW'(py[8:3]);
	assign raddr = AW'(rx_q) * AW'(PAGES) + AW'(rpage_q);
	assign addr  = (kind_q == pfb_pkg::KIND_READ) ? raddr : paddr;
	assign pbit  = py[2:0];
	assign wr_on = (cmd.src == pfb_pkg::SRC_CIRCLE) ? 1'b1 : on_q;
	assign wbyte = wr_on ? (rdat_q | (8'd1 << pbit)) : (rdat_q & ~(8'd1 << pbit));

	always_ff @(posedge clk) begin
		if (cmd.clr_write)
			mem[clr_q[AW-1:0]] <= '0;
		else if (cmd.wr_issue && onscreen)
			mem[paddr] <= wbyte;
		if (cmd.rd_issue)
			rdat_q <= mem[addr];
	end

	// circle arithmetic
	logic [16:0] rsq;
	logic [17:0] bsq, asq;
	logic [17:0] bb2;
	logic [17:0] aabb;
	logic [8:0]  a1;
	assign rsq  = {9'd0, radius} * {9'd0, radius};
	assign a1   = ca_q + 9'd1;
	assign bsq  = {9'd0, cb_q} * {9'd0, cb_q};
	assign asq  = {9'd0, a1} * {9'd0, a1};
	assign bb2  = {bsq[16:0], 1'b0};
	assign aabb = asq + bsq;

	// line stepping
	logic [9:0] ex_n, ey_n;
	assign ex_n = ex_q + 10'(dx_q);
	assign ey_n = ey_q + 10'(dy_q);

	logic [8:0] adx, ady;
	logic signed [8:0] sdx, sdy;
	assign sdx = $signed({1'b0, x_b}) - $signed({1'b0, x_a});
	assign sdy = $signed({1'b0, y_b}) - $signed({1'b0, y_a});
	assign adx = sdx[8] ? 9'(-sdx) : 9'(sdx);
	assign ady = sdy[8] ? 9'(-sdy) : 9'(sdy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_start) begin
			clr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			on_q    <= pixel_on;
			rx_q    <= x_a;
			rpage_q <= read_page;
			cx_q    <= 10'(x_a);
			cy_q    <= 10'(y_a);
			dx_q    <= adx;
			dy_q    <= ady;
			dist_q  <= (adx > ady) ? adx : ady;
			sx_q    <= sdx[8] ? -2'sd1 : ((sdx == 0) ? 2'sd0 : 2'sd1);
			sy_q    <= sdy[8] ? -2'sd1 : ((sdy == 0) ? 2'sd0 : 2'sd1);
			ex_q    <= '0;
			ey_q    <= '0;
			cnt_q   <= '0;
			ca_q    <= '0;
			cb_q    <= 9'(radius);
			rr_q    <= rsq;
			oct_q   <= '0;
			res_q   <= '0;
		end else begin
			if (cmd.pt_advance) begin
				if (cmd.src == pfb_pkg::SRC_LINE) begin
					cnt_q <= cnt_q + 1'b1;
					if (ex_n > 10'(dist_q)) begin
						ex_q <= ex_n - 10'(dist_q);
						cx_q <= cx_q + 10'(sx_q);
					end else begin
						ex_q <= ex_n;
					end
					if (ey_n > 10'(dist_q)) begin
						ey_q <= ey_n - 10'(dist_q);
						cy_q <= cy_q + 10'(sy_q);
					end else begin
						ey_q <= ey_n;
					end
				end else begin
					oct_q <= oct_q + 1'b1;
				end
			end
			if (cmd.cir_next) begin
				if (aabb > 18'(rr_q))
					cb_q <= cb_q - 1'b1;
				else
					ca_q <= a1;
			end
			if (cmd.rd_capture)
				res_q <= (rx_q < COLUMNS && {2'b0, rpage_q} < 4'(PAGES)) ? rdat_q : 8'd0;
		end
	end

	// radius zero draws only the centre: one group where all eight hit the centre
	assign sts.cir_cont = (rr_q == '0) ? (ca_q == 0 && cb_q == 0 && !cir_done_q)
		: (bb2 >= 18'(rr_q));
	always_ff @(posedge clk) begin
		if (cmd.load)
			cir_done_q <= 1'b0;
		else if (cmd.cir_next && rr_q == '0)
			cir_done_q <= 1'b1;
	end
	assign sts.clr_last = (clr_q == (AW + 1)'(DEPTH - 1));
	assign sts.pt_last  = (oct_q == 3'd7);
	assign sts.line_end = (cnt_q == dist_q);

	assign read_data = res_q;
	assign done_kind = kind_q;

endmodule
`default_nettype wire

// ===== design/page_framebuffer_line_circle_draw_unit.sv =====
// Top level of the page framebuffer raster engine: stream ports, controller, datapath.
// Depends on pfb_pkg, pfb_ctrl, pfb_datapath.
// One item at a time: the frame store has a single port and each pixel is a read
// followed by a write of the modified byte.
// Reset: asynchronous; after reset a clearing pass zeroes the store, during which
// no item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module page_framebuffer_line_circle_draw_unit #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// fields from bit 0: kind[2:0] x_a y_a x_b y_b radius pixel_on read_page, zero pad
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// fields from bit 0: read_data[7:0] done_kind[10:8], zero pad
	output logic [15:0]      m_tdata
);

	pfb_pkg::pfb_cmd_t cmd;
	pfb_pkg::pfb_sts_t sts;
	logic busy, done, in_fire, out_free;
	logic [7:0] rdata;
	logic [2:0] dkind;
	logic [15:0] out_q;
	logic out_v_q;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	// output register frees when empty or being taken
	assign out_free = !out_v_q || m_tready;

	pfb_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_kind(s_tdata[2:0]), .out_free, .sts, .cmd, .busy, .done
	);

	pfb_datapath #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_dp (
		.clk, .arst_n, .cmd,
		.kind(s_tdata[2:0]), .x_a(s_tdata[10:3]), .y_a(s_tdata[18:11]),
		.x_b(s_tdata[26:19]), .y_b(s_tdata[34:27]), .radius(s_tdata[42:35]),
		.pixel_on(s_tdata[43]), .read_page(s_tdata[45:44]),
		.sts, .read_data(rdata), .done_kind(dkind)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (done) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done)
			out_q <= {5'd0, dkind, rdata};
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("accept while busy");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> m_tvalid) else $error("result lost");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy) else $error("load did not start work");

endmodule
`default_nettype wire

// ===== test/pfb_checker.sv =====
// Checker for the page framebuffer raster engine: watches both stream channels,
// keeps its own copy of the frame store and compares each result item.
// Depends on pfb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfb_checker #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [15:0] m_tdata,
	output int               fail_count,
	output int               pending
);

	localparam int ROWS = PAGES * 8;

	typedef struct packed {
		logic [2:0] done_kind;
		logic [7:0] read_data;
	} result_t;

	logic [7:0] shadow_store [COLUMNS*PAGES];
	result_t    expected_results [$];

	function automatic void put_pixel(int x, int y, bit on);
		int idx;
		if (x < 0 || x >= COLUMNS || y < 0 || y >= ROWS)
			return;
		idx = x * PAGES + (y >> 3);
		if (on)
			shadow_store[idx][y & 7] = 1'b1;
		else
			shadow_store[idx][y & 7] = 1'b0;
	endfunction

	function automatic void trace_line(int x1, int y1, int x2, int y2, bit on);
		int dx, dy, sx, sy, span, ex, ey, cx, cy;
		dx = x2 - x1;
		dy = y2 - y1;
		sx = (dx > 0) ? 1 : (dx == 0) ? 0 : -1;
		sy = (dy > 0) ? 1 : (dy == 0) ? 0 : -1;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		span = (dx > dy) ? dx : dy;
		ex = 0;
		ey = 0;
		cx = x1;
		cy = y1;
		for (int t = 0; t <= span; t++) begin
			put_pixel(cx, cy, on);
			ex += dx;
			ey += dy;
			if (ex > span) begin
				ex -= span;
				cx += sx;
			end
			if (ey > span) begin
				ey -= span;
				cy += sy;
			end
		end
	endfunction

	function automatic void trace_circle(int x, int y, int r);
		int a, b, rr;
		a = 0;
		b = r;
		rr = r * r;
		if (r == 0) begin
			put_pixel(x, y, 1'b1);
			return;
		end
		while (2 * b * b >= rr) begin
			put_pixel(x + a, y - b, 1'b1);
			put_pixel(x - a, y - b, 1'b1);
			put_pixel(x - a, y + b, 1'b1);
			put_pixel(x + a, y + b, 1'b1);
			put_pixel(x + b, y + a, 1'b1);
			put_pixel(x + b, y - a, 1'b1);
			put_pixel(x - b, y - a, 1'b1);
			put_pixel(x - b, y + a, 1'b1);
			a++;
			if (a * a + b * b - rr > 0) begin
				b--;
				a--;
			end
		end
	endfunction

	// apply one command to the shadow store and return the result it yields
	function automatic result_t raster_command(logic [47:0] d);
		result_t res;
		int xa, ya, xb, yb, r, page;
		xa = int'(d[10:3]);
		ya = int'(d[18:11]);
		xb = int'(d[26:19]);
		yb = int'(d[34:27]);
		r = int'(d[42:35]);
		page = int'(d[45:44]);
		res.done_kind = d[2:0];
		res.read_data = '0;
		case (d[2:0])
			pfb_pkg::KIND_CLEAR:  foreach (shadow_store[i]) shadow_store[i] = '0;
			pfb_pkg::KIND_PIXEL:  put_pixel(xa, ya, d[43]);
			pfb_pkg::KIND_LINE:   trace_line(xa, ya, xb, yb, d[43]);
			pfb_pkg::KIND_CIRCLE: trace_circle(xa, ya, r);
			pfb_pkg::KIND_READ: begin
				if (xa < COLUMNS && page < PAGES)
					res.read_data = shadow_store[xa * PAGES + page];
			end
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want, got;
		int errs;
		errs = 0;
		if (!arst_n) begin
			foreach (shadow_store[i]) shadow_store[i] = '0;
			expected_results.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(raster_command(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[10:0];
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result item: expected none, actual %0d/%02h",
						$time, got.done_kind, got.read_data);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (got.done_kind !== want.done_kind) begin
						$display("%0t: done_kind mismatch: expected %0d, actual %0d",
							$time, want.done_kind, got.done_kind);
						errs++;
					end
					if (got.read_data !== want.read_data) begin
						$display("%0t: read_data mismatch (kind %0d): expected %02h, actual %02h",
							$time, want.done_kind, want.read_data, got.read_data);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			pending <= expected_results.size();
		end
	end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Testbench top for the page framebuffer raster engine: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on pfb_pkg, pfb_checker and the block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

	localparam int  COLUMNS = 128;
	localparam int  PAGES   = 4;
	localparam longint CYCLE_LIMIT = 3_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	int          fail_count;
	int          pending;
	longint      cycle_count = 0;
	bit          quiet_phase = 1'b0;  // no idling on either side
	int          sent_items = 0;
	int          kind_hist [8];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	page_framebuffer_line_circle_draw_unit #(.COLUMNS(COLUMNS), .PAGES(PAGES)) i_dut (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
	);

	pfb_checker #(.COLUMNS(COLUMNS), .PAGES(PAGES)) i_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
		.fail_count, .pending
	);

	// stall the result channel at random, about 12 percent of the time, except in the quiet phase
	always @(posedge clk) begin
		m_tready <= quiet_phase || ($urandom_range(99) >= 12);
	end

	// watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [47:0] pack_command(logic [2:0] kind, logic [7:0] xa,
		logic [7:0] ya, logic [7:0] xb, logic [7:0] yb, logic [7:0] r, logic on,
		logic [1:0] page);
		return {2'b00, page, on, r, yb, xb, ya, xa, kind};
	endfunction

	// offer one item, with random idle cycles ahead of it, and hold until accepted
	task automatic send_item(logic [47:0] d);
		while (!quiet_phase && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		// look at tready mid-cycle, then step to the accepting edge
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		kind_hist[d[2:0]]++;
		sent_items++;
	endtask

	task automatic send_cmd(logic [2:0] kind, int xa, int ya, int xb, int yb, int r,
		bit on, int page);
		send_item(pack_command(kind, 8'(xa), 8'(ya), 8'(xb), 8'(yb), 8'(r), on, 2'(page)));
	endtask

	// hold the input channel idle until every expected result has come
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// small coordinates land mostly on screen; sometimes pick any value
	function automatic int pick_col();
		return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(COLUMNS + 3);
	endfunction

	function automatic int pick_row();
		return ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(PAGES * 8 + 3);
	endfunction

	task automatic send_random();
		int sel, r;
		logic [2:0] kind;
		sel = $urandom_range(99);
		if (sel < 2)       kind = pfb_pkg::KIND_CLEAR;
		else if (sel < 25) kind = pfb_pkg::KIND_PIXEL;
		else if (sel < 47) kind = pfb_pkg::KIND_LINE;
		else if (sel < 62) kind = pfb_pkg::KIND_CIRCLE;
		else if (sel < 97) kind = pfb_pkg::KIND_READ;
		else               kind = 3'($urandom_range(5, 7));
		// keep circles mostly small; a few large ones for the far ends of the radius
		r = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(20);
		send_item(pack_command(kind, 8'(pick_col()), 8'(pick_row()), 8'(pick_col()),
			8'(pick_row()), 8'(r), $urandom_range(3) != 0, 2'($urandom_range(3))));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: store should read zero after reset, then corners and extremes
		send_cmd(pfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(pfb_pkg::KIND_PIXEL, 0, 0, 0, 0, 0, 1, 0);
		send_cmd(pfb_pkg::KIND_PIXEL, 127, 31, 0, 0, 0, 1, 0);
		send_cmd(pfb_pkg::KIND_PIXEL, 255, 255, 0, 0, 0, 1, 0);     // off screen, dropped
		send_cmd(pfb_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(pfb_pkg::KIND_READ, 127, 0, 0, 0, 0, 0, 3);
		send_cmd(pfb_pkg::KIND_READ, 255, 0, 0, 0, 0, 0, 3);        // off-screen read
		send_cmd(pfb_pkg::KIND_LINE, 0, 0, 127, 31, 0, 1, 0);
		send_cmd(pfb_pkg::KIND_LINE, 127, 0, 0, 31, 0, 1, 0);       // x steps negative, y positive
		send_cmd(pfb_pkg::KIND_LINE, 5, 20, 5, 2, 0, 0, 0);         // vertical, clearing
		send_cmd(pfb_pkg::KIND_LINE, 250, 250, 100, 10, 0, 1, 0);   // starts off screen
		send_cmd(pfb_pkg::KIND_LINE, 9, 9, 9, 9, 0, 1, 0);          // single point
		send_cmd(pfb_pkg::KIND_READ, 64, 0, 0, 0, 0, 0, 1);
		send_cmd(pfb_pkg::KIND_READ, 5, 0, 0, 0, 0, 0, 0);
		send_cmd(pfb_pkg::KIND_CIRCLE, 64, 16, 0, 0, 0, 1, 0);      // zero radius
		send_cmd(pfb_pkg::KIND_CIRCLE, 64, 16, 0, 0, 10, 1, 0);
		send_cmd(pfb_pkg::KIND_CIRCLE, 0, 0, 0, 0, 255, 1, 0);      // largest radius
		send_cmd(pfb_pkg::KIND_READ, 64, 0, 0, 0, 0, 0, 2);
		send_cmd(pfb_pkg::KIND_READ, 54, 0, 0, 0, 0, 0, 2);
		send_cmd(3'd5, 255, 255, 255, 255, 255, 1, 3);     // unused kinds change nothing
		send_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(pfb_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0);
		send_cmd(pfb_pkg::KIND_READ, 64, 0, 0, 0, 0, 0, 2);
		drain_results();

		// random part; the middle stretch runs with no idling at all
		for (int i = 0; i < 650; i++) begin
			quiet_phase = (i >= 250 && i < 350);
			send_random();
			if (i == 400)
				drain_results();
		end
		quiet_phase = 1'b0;
		drain_results();
		repeat (50) @(posedge clk);

		$display("Sent %0d items: %0d clear, %0d pixel, %0d line, %0d circle, %0d read, %0d unused.",
			sent_items, kind_hist[0], kind_hist[1], kind_hist[2], kind_hist[3], kind_hist[4],
			kind_hist[5] + kind_hist[6] + kind_hist[7]);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
